FILE: hdl/chtu_pkg.sv
package chtu_pkg;
  localparam int NUM_BUCKETS_DEF = 1024;
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int KEY_W = 64;
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] BUCKET_RESET = 11'd1021;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_DIV, S_HEAD_RD, S_HEAD_WT, S_CHECK, S_ENT_WT,
    S_INSERT, S_REMOVE, S_FREE_WT, S_OUT
  } state_e;
endpackage

FILE: hdl/chtu_ram.sv
module chtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hdl/chtu_divider.sv
// Restoring remainder, one quotient bit per cycle.
module chtu_divider #(
  parameter int DIV_W = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [chtu_pkg::KEY_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]          divisor_i,
  output logic                      done_o,
  output logic [DIV_W-1:0]          rem_o
);
  import chtu_pkg::*;
  localparam int IW = $clog2(KEY_W + 1);
  logic [KEY_W-1:0] sh_q, sh_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] dv_q, dv_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q;
  logic [DIV_W:0]   trial;

  always_comb begin
    sh_d = sh_q; rem_d = rem_q; dv_d = dv_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q[DIV_W-1:0], sh_q[KEY_W-1]};
    if (start_i) begin
      sh_d = dividend_i; rem_d = '0; dv_d = divisor_i;
      cnt_d = IW'(KEY_W); busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d = {sh_q[KEY_W-2:0], 1'b0};
      rem_d = (trial >= {1'b0, dv_q}) ? trial - {1'b0, dv_q} : trial;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == IW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_q <= busy_q && !busy_d;
    end
  end
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d; rem_q <= rem_d; dv_q <= dv_d;
  end
  assign done_o = done_q;
  assign rem_o = rem_q[DIV_W-1:0];
endmodule

FILE: hdl/chained_hash_table_u64.sv
// Hash map from 64-bit keys to values over separately chained buckets and a fixed
// entry pool. One transaction at a time: the bucket (key mod bucket_count, with
// bucket_count clamped to 1..NUM_BUCKETS) comes from a bit-serial remainder unit,
// then the bucket head is read, then each entry visited is read (registered RAM
// read), then, as needed, the end-of-chain check, update, free-list read and result.
// After reset, a clearing pass empties the bucket heads; no request is taken
// during it. Config writes are accepted always. Result sits in an output
// register until taken.
module chained_hash_table_u64 #(
  parameter int NUM_BUCKETS = chtu_pkg::NUM_BUCKETS_DEF,
  parameter int MAX_ENTRIES = chtu_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_WIDTH = chtu_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        req_valid_i,
  output logic                        req_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [chtu_pkg::KEY_W-1:0]  key_i,
  input  logic [VALUE_WIDTH-1:0]      value_i,
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output logic [1:0]                  status_o,
  output logic [31:0]                 found_value_o,
  output logic [chtu_pkg::CNT_W-1:0]  entry_count_o
);
  import chtu_pkg::*;
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int EW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int DW = $clog2(NUM_BUCKETS + 1);
  localparam int QW = (DW > CNT_W) ? DW : CNT_W;
  localparam logic [EW-1:0] NIL = EW'(MAX_ENTRIES);

  state_e st_q, st_d;
  logic [CNT_W-1:0] bcnt_q;
  logic [DW-1:0] eff;
  logic [1:0] rt_q, rt_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [BW-1:0] bkt_q, bkt_d, clr_q, clr_d;
  logic [EW-1:0] cur_q, cur_d, prev_q, prev_d, head_q, head_d;
  logic [EW-1:0] free_q, free_d, fresh_q, fresh_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [1:0] sto_q, sto_d;
  logic [31:0] fv_q, fv_d;
  logic resv_q, resv_d;

  logic hd_we; logic [BW-1:0] hd_wa, hd_ra; logic [EW-1:0] hd_wd, hd_rd;
  logic k_we; logic [AW-1:0] e_wa, e_ra; logic [KEY_W-1:0] k_rd;
  logic v_we; logic [VALUE_WIDTH-1:0] v_wd, v_rd;
  logic l_we; logic [AW-1:0] l_wa; logic [EW-1:0] l_wd, l_rd;
  logic dv_start, dv_done; logic [DW-1:0] dv_rem;
  logic [EW-1:0] alloc;

  always_comb begin
    if (bcnt_q == '0) eff = DW'(1);
    else if (QW'(bcnt_q) > QW'(NUM_BUCKETS)) eff = DW'(NUM_BUCKETS);
    else eff = DW'(bcnt_q);
  end

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == {REG_BUCKET_COUNT, 1'b0}) ? 32'(bcnt_q) : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bcnt_q <= BUCKET_RESET;
    else if (psel && penable && pwrite && paddr == {REG_BUCKET_COUNT, 1'b0})
      bcnt_q <= pwdata[CNT_W-1:0];
  end

  chtu_divider #(.DIV_W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .dividend_i(key_q), .divisor_i(eff),
    .done_o(dv_done), .rem_o(dv_rem));

  chtu_ram #(.WIDTH(EW), .DEPTH(NUM_BUCKETS)) u_heads (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra),
    .rdata_o(hd_rd));
  chtu_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_keys (
    .clk_i, .we_i(k_we), .waddr_i(e_wa), .wdata_i(key_q), .raddr_i(e_ra),
    .rdata_o(k_rd));
  chtu_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ENTRIES)) u_vals (
    .clk_i, .we_i(v_we), .waddr_i(e_wa), .wdata_i(v_wd), .raddr_i(e_ra),
    .rdata_o(v_rd));
  chtu_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_links (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(e_ra),
    .rdata_o(l_rd));

  assign req_stall_o = (st_q != S_IDLE) || resv_q;
  assign res_valid_o = resv_q;
  assign status_o = sto_q;
  assign found_value_o = fv_q;
  assign entry_count_o = held_q;
  assign alloc = (free_q != NIL) ? free_q : fresh_q;

  always_comb begin
    st_d = st_q; rt_d = rt_q; key_d = key_q; val_d = val_q; bkt_d = bkt_q;
    clr_d = clr_q; cur_d = cur_q; prev_d = prev_q; head_d = head_q;
    free_d = free_q; fresh_d = fresh_q; held_d = held_q; sto_d = sto_q;
    fv_d = fv_q; resv_d = resv_q;
    hd_we = 1'b0; hd_wa = bkt_q; hd_wd = NIL; hd_ra = bkt_q;
    k_we = 1'b0; v_we = 1'b0; l_we = 1'b0;
    e_wa = cur_q[AW-1:0]; e_ra = cur_q[AW-1:0]; v_wd = val_q;
    l_wa = cur_q[AW-1:0]; l_wd = NIL;
    dv_start = 1'b0;
    if (resv_q && !res_stall_i) resv_d = 1'b0;
    unique case (st_q)
      S_CLEAR: begin
        hd_we = 1'b1; hd_wa = clr_q; hd_wd = NIL;
        clr_d = clr_q + 1'b1;
        if (clr_q == BW'(NUM_BUCKETS - 1)) st_d = S_IDLE;
      end
      S_IDLE: if (req_valid_i && !req_stall_o) begin
        rt_d = req_type_i; key_d = key_i; val_d = value_i;
        st_d = S_DIV;
        dv_start = 1'b0;
      end
      S_DIV: begin
        if (rt_q == 2'd3) begin
          sto_d = ST_MISSING; fv_d = '0; st_d = S_OUT;
        end else begin
          dv_start = 1'b1;
          st_d = S_HEAD_RD;
        end
      end
      S_HEAD_RD: if (dv_done) begin
        bkt_d = BW'(dv_rem); hd_ra = BW'(dv_rem); st_d = S_HEAD_WT;
      end
      S_HEAD_WT: begin
        head_d = hd_rd; cur_d = hd_rd; prev_d = NIL; st_d = S_CHECK;
      end
      S_CHECK: begin
        if (cur_q >= NIL) begin
          if (rt_q == REQ_INSERT) st_d = S_INSERT;
          else begin sto_d = ST_MISSING; fv_d = '0; st_d = S_OUT; end
        end else begin
          e_ra = cur_q[AW-1:0]; st_d = S_ENT_WT;
        end
      end
      S_ENT_WT: begin
        if (k_rd == key_q) begin
          sto_d = ST_DONE; fv_d = '0;
          if (rt_q == REQ_INSERT) begin
            v_we = 1'b1; e_wa = cur_q[AW-1:0]; st_d = S_OUT;
          end else if (rt_q == REQ_LOOKUP) begin
            fv_d = 32'(v_rd); st_d = S_OUT;
          end else begin
            if (prev_q == NIL) begin
              hd_we = 1'b1; hd_wd = l_rd;
            end else begin
              l_we = 1'b1; l_wa = prev_q[AW-1:0]; l_wd = l_rd;
            end
            st_d = S_REMOVE;
          end
        end else begin
          prev_d = cur_q; cur_d = l_rd; st_d = S_CHECK;
        end
      end
      S_REMOVE: begin
        l_we = 1'b1; l_wa = cur_q[AW-1:0]; l_wd = free_q;
        free_d = cur_q;
        if (held_q != '0) held_d = held_q - 1'b1;
        st_d = S_OUT;
      end
      S_INSERT: begin
        fv_d = '0;
        if (alloc >= NIL) begin
          sto_d = ST_FULL; st_d = S_OUT;
        end else begin
          sto_d = ST_DONE;
          k_we = 1'b1; v_we = 1'b1; e_wa = alloc[AW-1:0];
          l_we = 1'b1; l_wa = alloc[AW-1:0]; l_wd = head_q;
          hd_we = 1'b1; hd_wd = alloc;
          held_d = held_q + 1'b1;
          if (free_q != NIL) begin
            e_ra = free_q[AW-1:0]; st_d = S_FREE_WT;
          end else begin
            fresh_d = fresh_q + 1'b1; st_d = S_OUT;
          end
        end
      end
      S_FREE_WT: begin
        free_d = l_rd; st_d = S_OUT;
      end
      S_OUT: begin
        resv_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR; clr_q <= '0; free_q <= NIL; fresh_q <= '0;
      held_q <= '0; resv_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; free_q <= free_d; fresh_q <= fresh_d;
      held_q <= held_d; resv_q <= resv_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rt_q <= rt_d; key_q <= key_d; val_q <= val_d; bkt_q <= bkt_d;
    cur_q <= cur_d; prev_q <= prev_d; head_q <= head_d;
    sto_q <= sto_d; fv_q <= fv_d;
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> req_stall_o) else $error("accepted while busy");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_stall_i) |=> (res_valid_o && $stable(status_o)))
    else $error("result dropped");
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q <= CNT_W'(MAX_ENTRIES))) else $error("count overflow");
endmodule

FILE: tb/chained_hash_table_u64_tb.sv
`timescale 1ns / 100ps

module chained_hash_table_u64_tb;
  import chtu_pkg::*;

  localparam int NB = NUM_BUCKETS_DEF;
  localparam int NE = MAX_ENTRIES_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [31:0] val;
    bit          typed;
    logic [1:0]  st;
    logic [31:0] fv;
    logic [10:0] cnt;
  } stim_row_t;

  typedef struct {
    logic [1:0]  st;
    logic [31:0] fv;
    logic [10:0] cnt;
  } outcome_t;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        req_valid, req_stall_o;
  logic [1:0]  req_type;
  logic [63:0] key;
  logic [31:0] value;
  logic        res_valid_o, res_stall;
  logic [1:0]  status_o;
  logic [31:0] found_value_o;
  logic [10:0] entry_count_o;

  chained_hash_table_u64 dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req_valid_i(req_valid), .req_stall_o, .req_type_i(req_type), .key_i(key),
    .value_i(value), .res_valid_o, .res_stall_i(res_stall), .status_o,
    .found_value_o, .entry_count_o
  );

  // shadow table
  int unsigned     bucket_reg;
  int unsigned     heads [NB];
  logic [63:0]     ent_key [NE];
  logic [31:0]     ent_val [NE];
  int unsigned     ent_link [NE];
  int unsigned     free_head, next_fresh, held;

  outcome_t        pending [$];
  int unsigned     errors, n_req, n_res, n_full, n_hit;
  int unsigned     quiet_cycles;
  bit              no_idle, hold_off;
  logic [63:0]     key_pool [32];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned chain_find(int unsigned b, logic [63:0] k,
                                             output int unsigned prev);
    int unsigned cur, steps;
    cur = heads[b];
    prev = NE;
    steps = 0;
    while (cur < NE && steps < NE) begin
      if (ent_key[cur] == k) return cur;
      prev = cur;
      cur = ent_link[cur];
      steps++;
    end
    prev = NE;
    return NE;
  endfunction

  function automatic outcome_t table_apply(logic [1:0] kind, logic [63:0] k,
                                           logic [31:0] v);
    outcome_t o;
    int unsigned mods, b, hit, prev, e;
    mods = (bucket_reg == 0) ? 1 : (bucket_reg > NB) ? NB : bucket_reg;
    b = int'(k % 64'(mods));
    o.st = ST_MISSING;
    o.fv = '0;
    if (kind != REQ_UNUSED) hit = chain_find(b, k, prev);
    case (kind)
      REQ_INSERT: begin
        if (hit != NE) begin
          ent_val[hit] = v;
          o.st = ST_DONE;
        end else begin
          e = NE;
          if (free_head < NE) begin
            e = free_head;
            free_head = ent_link[e];
          end else if (next_fresh < NE) begin
            e = next_fresh;
            next_fresh++;
          end
          if (e == NE) o.st = ST_FULL;
          else begin
            ent_key[e] = k;
            ent_val[e] = v;
            ent_link[e] = heads[b];
            heads[b] = e;
            held++;
            o.st = ST_DONE;
          end
        end
      end
      REQ_LOOKUP: if (hit != NE) begin
        o.fv = ent_val[hit];
        o.st = ST_DONE;
      end
      REQ_REMOVE: if (hit != NE) begin
        if (prev == NE) heads[b] = ent_link[hit];
        else ent_link[prev] = ent_link[hit];
        ent_link[hit] = free_head;
        free_head = hit;
        if (held > 0) held--;
        o.st = ST_DONE;
      end
      default: ;
    endcase
    o.cnt = 11'(held);
    return o;
  endfunction

  task automatic issue(stim_row_t r);
    int unsigned g;
    outcome_t o;
    g = no_idle ? 0 : $urandom_range(0, 19);
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_type <= r.kind;
    key <= r.key;
    value <= r.val;
    do @(posedge clk_i); while (req_stall_o);
    o = table_apply(r.kind, r.key, r.val);
    if (r.typed) begin
      o.st = r.st;
      o.fv = r.fv;
      o.cnt = r.cnt;
    end
    if (o.st == ST_FULL) n_full++;
    if (r.kind == REQ_LOOKUP && o.st == ST_DONE) n_hit++;
    pending.push_back(o);
    n_req++;
  endtask

  task automatic send(logic [1:0] kind, logic [63:0] k, logic [31:0] v);
    stim_row_t r;
    r = '{kind, k, v, 1'b0, '0, '0, '0};
    issue(r);
  endtask

  task automatic drain_and_write(logic [31:0] d);
    req_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (2200) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {1'b0, REG_BUCKET_COUNT};
    pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    bucket_reg = d[10:0];
    @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned p;
    logic [1:0] kind;
    logic [63:0] k;
    for (int i = 0; i < 32; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      kind = p < 40 ? REQ_INSERT : p < 70 ? REQ_LOOKUP : p < 95 ? REQ_REMOVE : REQ_UNUSED;
      k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                       : key_pool[$urandom_range(0, 31)];
      if (i % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send(kind, k, $urandom);
    end
    no_idle = 1'b0;
  endtask

  // result side
  initial begin
    int unsigned n;
    res_stall = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        res_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
      end
      n = no_idle ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      res_stall <= 1'b0;
      do @(posedge clk_i); while (!res_valid_o);
    end
  end

  always @(posedge clk_i) begin
    outcome_t o;
    if (rst_ni && res_valid_o && !res_stall) begin
      n_res++;
      if (pending.size() == 0) begin
        errors++;
        $error("result with nothing outstanding");
      end else begin
        o = pending.pop_front();
        if (status_o !== o.st) begin
          errors++;
          $error("status: expected %0d, got %0d", o.st, status_o);
        end
        if (found_value_o !== o.fv) begin
          errors++;
          $error("found_value: expected %0h, got %0h", o.fv, found_value_o);
        end
        if (entry_count_o !== o.cnt) begin
          errors++;
          $error("entry_count: expected %0d, got %0d", o.cnt, entry_count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid && !req_stall_o) || (res_valid_o && !res_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    stim_row_t dir [$];
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_valid = 1'b0;
    req_type = REQ_LOOKUP;
    key = '0;
    value = '0;
    errors = 0;
    n_req = 0;
    n_res = 0;
    n_full = 0;
    n_hit = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    hold_off = 1'b0;
    bucket_reg = BUCKET_RESET;
    for (int i = 0; i < NB; i++) heads[i] = NE;
    free_head = NE;
    next_fresh = 0;
    held = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir = '{
      '{REQ_LOOKUP, 64'd0, 32'd0, 1, ST_MISSING, 32'd0, 11'd0},
      '{REQ_REMOVE, 64'd5, 32'd0, 1, ST_MISSING, 32'd0, 11'd0},
      '{REQ_INSERT, 64'd0, 32'hFFFF_FFFF, 1, ST_DONE, 32'd0, 11'd1},
      '{REQ_LOOKUP, 64'd0, 32'd0, 1, ST_DONE, 32'hFFFF_FFFF, 11'd1},
      '{REQ_INSERT, '1, 32'd0, 1, ST_DONE, 32'd0, 11'd2},
      '{REQ_LOOKUP, '1, 32'hDEAD_BEEF, 1, ST_DONE, 32'd0, 11'd2},
      '{REQ_INSERT, '1, 32'hA5A5_5A5A, 1, ST_DONE, 32'd0, 11'd2},
      '{REQ_LOOKUP, '1, 32'd0, 1, ST_DONE, 32'hA5A5_5A5A, 11'd2},
      '{REQ_INSERT, 64'd1021, 32'd7, 1, ST_DONE, 32'd0, 11'd3},
      '{REQ_INSERT, 64'd2042, 32'd8, 1, ST_DONE, 32'd0, 11'd4},
      '{REQ_LOOKUP, 64'd1021, 32'd0, 1, ST_DONE, 32'd7, 11'd4},
      '{REQ_REMOVE, 64'd2042, 32'd0, 1, ST_DONE, 32'd0, 11'd3},
      '{REQ_LOOKUP, 64'd2042, 32'd0, 1, ST_MISSING, 32'd0, 11'd3},
      '{REQ_REMOVE, 64'd0, 32'd0, 1, ST_DONE, 32'd0, 11'd2},
      '{REQ_INSERT, 64'd3063, 32'd9, 1, ST_DONE, 32'd0, 11'd3},
      '{REQ_UNUSED, 64'd3063, 32'd1, 1, ST_MISSING, 32'd0, 11'd3},
      '{REQ_REMOVE, 64'd1021, 32'd0, 1, ST_DONE, 32'd0, 11'd2},
      '{REQ_LOOKUP, 64'd3063, 32'd0, 1, ST_DONE, 32'd9, 11'd2},
      '{REQ_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 0, '0, '0, '0},
      '{REQ_LOOKUP, 64'h8000_0000_0000_0000, 32'd0, 0, '0, '0, '0}
    };
    foreach (dir[i]) issue(dir[i]);

    drain_and_write(32'd0);
    random_phase(60);
    drain_and_write(32'd2047);
    hold_off = 1'b1;
    random_phase(250);
    drain_and_write(32'd7);
    random_phase(250);
    drain_and_write(32'd1);
    random_phase(40);
    drain_and_write($urandom_range(2, 1024));
    random_phase(250);
    drain_and_write(32'd1024);
    hold_off = 1'b1;
    random_phase(100);

    // fill the pool, then hit it while full
    no_idle = 1'b1;
    while (held < NE) send(REQ_INSERT, {$urandom, $urandom}, $urandom);
    no_idle = 1'b0;
    for (int i = 0; i < 12; i++) send(REQ_INSERT, {$urandom, $urandom}, $urandom);
    send(REQ_INSERT, ent_key[5], 32'h1234_5678);
    send(REQ_LOOKUP, ent_key[5], '0);
    send(REQ_REMOVE, ent_key[9], '0);
    send(REQ_INSERT, 64'hFFFF_0000_FFFF_0000, 32'd3);
    send(REQ_INSERT, 64'h0000_FFFF_0000_FFFF, 32'd4);
    req_valid <= 1'b0;

    while (pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d requests, %0d results, %0d lookup hits, %0d pool-full rejects",
             n_req, n_res, n_hit, n_full);
    $display("bucket counts 1021, 0, 2047, 7, 1, random, 1024; %0d mismatches", errors);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
